/* design/ffba_pkg.sv */
// Shared types, widths and codes for the first-fit block allocator.
package ffba_pkg;

    localparam int MAX_USERS_DEF = 8;
    localparam int POOL_CAPACITY = 4096;

    localparam int KIND_W     = 2;
    localparam int USER_W     = 8;
    localparam int SIZE_W     = 13;
    localparam int ADDR_W     = 12;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 80;

    localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(4096);
    localparam logic [SIZE_W-1:0] POOL_CAP_W = SIZE_W'(POOL_CAPACITY);

    // Result bit positions in the output tdata
    localparam int OB_OK   = 0;
    localparam int OB_BASE = 1;
    localparam int OB_CAP  = 13;
    localparam int OB_HELD = 26;
    localparam int OB_SRC  = 39;
    localparam int OB_DST  = 51;
    localparam int OB_LEN  = 63;
    localparam int OB_MOVE = 76;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_FREE   = 2'd1,
        KIND_DEFRAG = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        RES_FAIL  = 2'd0,
        RES_OK    = 2'd1,
        RES_GRANT = 2'd2
    } res_code_t;

    typedef struct packed {
        logic      load;
        logic      idx_clr;
        logic      idx_inc;
        logic      rel_remove;
        logic      fit_insert;
        logic      fit_advance;
        logic      def_step;
        logic      emit;
        res_code_t code;
    } ffba_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  bad_size;
        logic  scan_end;
        logic  user_hit;
        logic  table_full;
        logic  table_empty;
        logic  gap_fits;
        logic  def_last;
        logic  out_free;
    } ffba_status_t;

endpackage

/* design/ffba_ctrl.sv */
// Controller state machine sequencing release, fit, defrag and result steps.
module ffba_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ffba_pkg::ffba_status_t status,
    input  logic                 in_take,
    output ffba_pkg::ffba_cmd_t    cmd,
    output logic                 in_ready
);
    import ffba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RELEASE,
        S_CHECK,
        S_FIT,
        S_DEFRAG,
        S_EMIT
    } state_t;

    state_t    state_reg, state_next;
    res_code_t code_reg, code_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.code   = code_reg;
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = 1'b1;
                if (in_take)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.idx_clr = 1'b1;
                case (status.kind)
                    KIND_ALLOC:
                    begin
                        if (status.bad_size)
                        begin
                            code_next  = RES_FAIL;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_RELEASE;
                        end
                    end
                    KIND_FREE:
                    begin
                        state_next = S_RELEASE;
                    end
                    KIND_DEFRAG:
                    begin
                        if (status.table_empty)
                        begin
                            code_next  = RES_OK;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_DEFRAG;
                        end
                    end
                    default:
                    begin
                        code_next  = RES_FAIL;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_RELEASE:
            begin
                if (status.scan_end || status.user_hit)
                begin
                    cmd.rel_remove = !status.scan_end;
                    if (status.kind == KIND_FREE)
                    begin
                        code_next  = RES_OK;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_CHECK:
            begin
                if (status.table_full)
                begin
                    code_next  = RES_FAIL;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_FIT;
                end
            end
            S_FIT:
            begin
                if (status.gap_fits)
                begin
                    cmd.fit_insert = 1'b1;
                    code_next      = RES_GRANT;
                    state_next     = S_EMIT;
                end
                else if (status.scan_end)
                begin
                    code_next  = RES_FAIL;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.fit_advance = 1'b1;
                end
            end
            S_DEFRAG:
            begin
                if (status.out_free)
                begin
                    cmd.def_step = 1'b1;
                    if (status.def_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result code for the emit step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= RES_FAIL;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

/* design/ffba_dp.sv */
// Datapath: block table, scan pointer, running totals and result register.
module ffba_dp #(
    parameter int MAX_USERS = ffba_pkg::MAX_USERS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ffba_pkg::ffba_cmd_t              cmd,
    output ffba_pkg::ffba_status_t           status,
    input  logic                             in_take,
    input  logic [ffba_pkg::KIND_W-1:0]      in_kind,
    input  logic [ffba_pkg::USER_W-1:0]      in_user,
    input  logic [ffba_pkg::SIZE_W-1:0]      in_size,
    input  logic                             cfg_wr_en,
    input  logic [ffba_pkg::SIZE_W-1:0]      cfg_wr_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ffba_pkg::OUT_DATA_W-1:0]  out_data,
    output logic                             out_last
);
    import ffba_pkg::*;

    localparam int IW  = $clog2(MAX_USERS + 1);
    localparam int IXW = $clog2(MAX_USERS);

    logic [USER_W-1:0] user_reg [MAX_USERS];
    logic [SIZE_W-1:0] base_reg [MAX_USERS];
    logic [SIZE_W-1:0] size_reg [MAX_USERS];

    kind_t             kind_q_reg;
    logic [USER_W-1:0] user_q_reg;
    logic [SIZE_W-1:0] size_q_reg;
    logic [SIZE_W-1:0] pool_reg;
    logic [IW-1:0]     count_reg;
    logic [IW-1:0]     idx_reg;
    logic [SIZE_W-1:0] pbase_reg;
    logic [SIZE_W-1:0] held_reg;
    logic              out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic              out_last_next;

    logic [IXW-1:0]    sel;
    logic [USER_W-1:0] cur_user;
    logic [SIZE_W-1:0] cur_base;
    logic [SIZE_W-1:0] cur_size;
    logic [SIZE_W-1:0] usable;
    logic [SIZE_W-1:0] gap_end;
    logic              scan_end;
    logic              moved;
    logic [SIZE_W-1:0] dest;
    logic              def_last;
    logic              out_free;
    logic [IW-1:0]     idx_plus;

    assign sel      = idx_reg[IXW-1:0];
    assign cur_user = user_reg[sel];
    assign cur_base = base_reg[sel];
    assign cur_size = size_reg[sel];
    assign usable   = (pool_reg < POOL_CAP_W) ? pool_reg : POOL_CAP_W;
    assign scan_end = (idx_reg == count_reg);
    assign gap_end  = scan_end ? usable : cur_base;
    assign moved    = (cur_base > pbase_reg);
    assign dest     = moved ? pbase_reg : cur_base;
    assign idx_plus = idx_reg + IW'(1);
    assign def_last = (idx_plus == count_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        status             = '0;
        status.kind        = kind_q_reg;
        status.bad_size    = (size_q_reg == '0) || (size_q_reg > usable);
        status.scan_end    = scan_end;
        status.user_hit    = !scan_end && (cur_user == user_q_reg);
        status.table_full  = (count_reg >= IW'(MAX_USERS));
        status.table_empty = (count_reg == '0);
        status.gap_fits    = (gap_end >= pbase_reg) && ((gap_end - pbase_reg) >= size_q_reg);
        status.def_last    = def_last;
        status.out_free    = out_free;
    end

    // Table entries: close up on remove, open a slot on insert, slide base on defrag
    for (genvar m = 0; m < MAX_USERS; m++)
    begin : g_ent
        localparam int UP = (m < MAX_USERS - 1) ? m + 1 : m;
        localparam int DN = (m > 0) ? m - 1 : m;

        always_ff @(posedge clk)
        begin
            if (cmd.rel_remove)
            begin
                if (IW'(m) >= idx_reg)
                begin
                    user_reg[m] <= user_reg[UP];
                    base_reg[m] <= base_reg[UP];
                    size_reg[m] <= size_reg[UP];
                end
            end
            else if (cmd.fit_insert)
            begin
                if (IW'(m) == idx_reg)
                begin
                    user_reg[m] <= user_q_reg;
                    base_reg[m] <= pbase_reg;
                    size_reg[m] <= size_q_reg;
                end
                else if (IW'(m) > idx_reg)
                begin
                    user_reg[m] <= user_reg[DN];
                    base_reg[m] <= base_reg[DN];
                    size_reg[m] <= size_reg[DN];
                end
            end
            else if (cmd.def_step && (IW'(m) == idx_reg))
            begin
                base_reg[m] <= dest;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg      <= POOL_RESET;
            count_reg     <= '0;
            idx_reg       <= '0;
            pbase_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pool_reg <= cfg_wr_data;
            end
            if (cmd.idx_clr)
            begin
                idx_reg   <= '0;
                pbase_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_plus;
            end
            else if (cmd.fit_advance)
            begin
                idx_reg   <= idx_plus;
                pbase_reg <= cur_base + cur_size;
            end
            else if (cmd.def_step)
            begin
                idx_reg   <= idx_plus;
                pbase_reg <= dest + cur_size;
            end
            if (cmd.rel_remove)
            begin
                count_reg <= count_reg - IW'(1);
                held_reg  <= held_reg - cur_size;
            end
            else if (cmd.fit_insert)
            begin
                count_reg <= count_reg + IW'(1);
                held_reg  <= held_reg + size_q_reg;
            end
            if (cmd.emit || cmd.def_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload for a defrag step or a single emitted result
    always_comb
    begin
        out_data_next                    = '0;
        out_last_next                    = 1'b1;
        out_data_next[OB_HELD +: SIZE_W] = held_reg;
        if (cmd.def_step)
        begin
            out_data_next[OB_OK]            = 1'b1;
            out_data_next[OB_SRC +: ADDR_W] = cur_base[ADDR_W-1:0];
            out_data_next[OB_DST +: ADDR_W] = dest[ADDR_W-1:0];
            out_data_next[OB_LEN +: SIZE_W] = cur_size;
            out_data_next[OB_MOVE]          = moved;
            out_last_next                   = def_last;
        end
        else
        begin
            case (cmd.code)
                RES_OK:
                begin
                    out_data_next[OB_OK] = 1'b1;
                end
                RES_GRANT:
                begin
                    out_data_next[OB_OK]             = 1'b1;
                    out_data_next[OB_BASE +: ADDR_W] = pbase_reg[ADDR_W-1:0];
                    out_data_next[OB_CAP +: SIZE_W]  = size_q_reg;
                end
                default:
                begin
                    out_data_next[OB_OK] = 1'b0;
                end
            endcase
        end
    end

    // Request capture and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load && in_take)
        begin
            kind_q_reg <= kind_t'(in_kind);
            user_q_reg <= in_user;
            size_q_reg <= in_size;
        end
        if (cmd.def_step || cmd.emit)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

/* design/first_fit_block_allocator_unit.sv */
// Top level of the first-fit block allocator: controller plus table datapath.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser = kind, tdata = user_id, size
//  m_axis    out  tvalid/tready, tlast   tdata = ok .. is_move, tlast = last
//  cfg       in   cfg_wr_en              cfg_wr_data = pool_size
//
// One request is in work at a time. The block table has a single read port,
// so every scan visits one entry per cycle, the defragment scan only while
// the result side is not stalled. A stalled result holds the block in its
// current step; a new request is taken as soon as the previous one has put
// its last result in the output register. Reset empties the table at once.
module first_fit_block_allocator_unit #(
    parameter int MAX_USERS = ffba_pkg::MAX_USERS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ffba_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // user_id[7:0], size[20:8], pad
    input  logic [ffba_pkg::KIND_W-1:0]      s_axis_tuser,  // kind[1:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // ok[0], base[12:1], capacity[25:13], bytes_held[38:26], move_source[50:39],
    // move_dest[62:51], move_length[75:63], is_move[76], pad[79:77]
    output logic [ffba_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             cfg_wr_en,
    input  logic [ffba_pkg::SIZE_W-1:0]      cfg_wr_data
);
    import ffba_pkg::*;

    ffba_cmd_t    cmd;
    ffba_status_t status;
    logic         in_take;

    // A request is taken only while the controller is idle
    assign in_take = s_axis_tvalid && s_axis_tready;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .cmd      (cmd),
        .in_ready (s_axis_tready),
        .in_take  (in_take)
    );

    ffba_dp #(
        .MAX_USERS (MAX_USERS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_take     (in_take),
        .in_kind     (s_axis_tuser),
        .in_user     (s_axis_tdata[USER_W-1:0]),
        .in_size     (s_axis_tdata[USER_W +: SIZE_W]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

endmodule

/* design/ffba_checker.sv */
// Port-level checks for the first-fit block allocator, bound to the top level.
module ffba_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ffba_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tlast
);
    import ffba_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // One request in work: drop ready right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // A failed result carries only bytes held
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[OB_OK] |->
            m_axis_tdata[OB_HELD-1:OB_BASE] == '0 && m_axis_tdata[OB_MOVE:OB_SRC] == '0
            && m_axis_tlast)
        else $error("failed result has payload");

    // A relocation always moves a block down
    a_move_down: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OB_MOVE] |->
            m_axis_tdata[OB_DST +: ADDR_W] < m_axis_tdata[OB_SRC +: ADDR_W])
        else $error("move does not go down");

    // A granted block counts toward bytes held
    a_grant_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OB_OK] && m_axis_tdata[OB_CAP +: SIZE_W] != '0 |->
            m_axis_tdata[OB_CAP +: SIZE_W] <= m_axis_tdata[OB_HELD +: SIZE_W])
        else $error("grant exceeds bytes held");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (.*);

/* verif/testbench.sv */
// Self-checking testbench for the first-fit block allocator unit.
module testbench;
    import ffba_pkg::*;

    localparam int TB_USERS     = MAX_USERS_DEF;
    localparam int DIRECTED_CNT = 27;
    localparam int PHASE_CNT    = 7;
    localparam int PHASE_ITEMS  = 64;
    // Worst case per request: 8 results, each behind the longest receiver stall,
    // plus the sender gap and the longest allocate scan, for ~475 requests.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 100;

    // The package enum has no member for the fourth tuser code.
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    // One result beat as it leaves the block.
    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] cap;
        logic [SIZE_W-1:0] held;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [SIZE_W-1:0] len;
        logic              mv;
        logic              last;
    } alloc_record_t;

    // Directed request, with a typed-in first result where it is obvious.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [USER_W-1:0] user;
        logic [SIZE_W-1:0] size;
        logic              typed;
        logic              ok;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] cap;
        logic [SIZE_W-1:0] held;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic [KIND_W-1:0]     s_kind = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  m_last;
    logic                  cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0]     cfg_wr_data = '0;

    // Shadow of the block table and the pool register.
    int unsigned tbl_user [TB_USERS];
    int unsigned tbl_base [TB_USERS];
    int unsigned tbl_size [TB_USERS];
    int unsigned tbl_count;
    int unsigned pool_reg;

    alloc_record_t pending_records [$];
    int            errors;
    int            cycle_count;
    int            burst_left;
    int            ready_left;
    int            ready_mode;

    // Rows from reset: empty-table corner cases, full-pool grant, first-fit reuse,
    // re-allocation, compaction with moves, table full, full-table compaction.
    directed_row_t directed_rows [DIRECTED_CNT] = '{
        '{KIND_DEFRAG,  8'd0,   13'd0,    1'b1, 1'b1, 12'd0,   13'd0,    13'd0},
        '{KIND_FREE,    8'd5,   13'd0,    1'b1, 1'b1, 12'd0,   13'd0,    13'd0},
        '{KIND_ALLOC,   8'd0,   13'd0,    1'b1, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_ALLOC,   8'd255, 13'd8191, 1'b1, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_ALLOC,   8'd1,   13'd4097, 1'b1, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_UNKNOWN, 8'd255, 13'd8191, 1'b1, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_ALLOC,   8'd1,   13'd4096, 1'b1, 1'b1, 12'd0,   13'd4096, 13'd4096},
        '{KIND_ALLOC,   8'd2,   13'd1,    1'b1, 1'b0, 12'd0,   13'd0,    13'd4096},
        '{KIND_FREE,    8'd1,   13'd0,    1'b1, 1'b1, 12'd0,   13'd0,    13'd0},
        '{KIND_ALLOC,   8'd1,   13'd100,  1'b1, 1'b1, 12'd0,   13'd100,  13'd100},
        '{KIND_ALLOC,   8'd2,   13'd200,  1'b1, 1'b1, 12'd100, 13'd200,  13'd300},
        '{KIND_ALLOC,   8'd3,   13'd50,   1'b1, 1'b1, 12'd300, 13'd50,   13'd350},
        '{KIND_FREE,    8'd2,   13'd0,    1'b1, 1'b1, 12'd0,   13'd0,    13'd150},
        '{KIND_ALLOC,   8'd4,   13'd60,   1'b1, 1'b1, 12'd100, 13'd60,   13'd210},
        '{KIND_ALLOC,   8'd1,   13'd5000, 1'b1, 1'b0, 12'd0,   13'd0,    13'd210},
        '{KIND_ALLOC,   8'd3,   13'd300,  1'b0, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_FREE,    8'd4,   13'd0,    1'b0, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_DEFRAG,  8'd0,   13'd0,    1'b0, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_ALLOC,   8'd10,  13'd1,    1'b0, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_ALLOC,   8'd11,  13'd1,    1'b0, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_ALLOC,   8'd12,  13'd1,    1'b0, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_ALLOC,   8'd13,  13'd1,    1'b0, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_ALLOC,   8'd14,  13'd1,    1'b0, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_ALLOC,   8'd15,  13'd1,    1'b0, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_ALLOC,   8'd20,  13'd1,    1'b0, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_ALLOC,   8'd10,  13'd2,    1'b0, 1'b0, 12'd0,   13'd0,    13'd0},
        '{KIND_DEFRAG,  8'd0,   13'd0,    1'b0, 1'b0, 12'd0,   13'd0,    13'd0}
    };

    // Pool settings per random phase; zero marks a random size.
    logic [SIZE_W-1:0] phase_pools [PHASE_CNT] = '{
        13'd64, 13'd1, 13'd8191, 13'd300, 13'd0, 13'd4096, 13'd2048
    };

    first_fit_block_allocator_unit #(
        .MAX_USERS (TB_USERS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_kind),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: alternate long ready stretches, short stalls and rare long stalls.
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 9);
            if (ready_mode < 5)
            begin
                m_ready <= 1'b1;
                ready_left = $urandom_range(1, 30);
            end
            else if (ready_mode < 9)
            begin
                m_ready <= 1'b0;
                ready_left = $urandom_range(1, 4);
            end
            else
            begin
                m_ready <= 1'b0;
                ready_left = $urandom_range(10, 20);
            end
        end
        else
        begin
            ready_left = ready_left - 1;
        end
    end

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_LIMIT)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        errors = errors + 1;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Compare one accepted result beat with the oldest predicted record.
    task automatic check_result();
        alloc_record_t want;
        if (pending_records.size() == 0)
        begin
            report_mismatch("result with no request outstanding");
            return;
        end
        want = pending_records.pop_front();
        check_field("ok",          m_data[OB_OK],                want.ok);
        check_field("base",        m_data[OB_BASE +: ADDR_W],    want.base);
        check_field("capacity",    m_data[OB_CAP  +: SIZE_W],    want.cap);
        check_field("bytes_held",  m_data[OB_HELD +: SIZE_W],    want.held);
        check_field("move_source", m_data[OB_SRC  +: ADDR_W],    want.src);
        check_field("move_dest",   m_data[OB_DST  +: ADDR_W],    want.dst);
        check_field("move_length", m_data[OB_LEN  +: SIZE_W],    want.len);
        check_field("is_move",     m_data[OB_MOVE],              want.mv);
        check_field("last",        m_last,                       want.last);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_valid && m_ready)
            check_result();
    end

    // Append one record; bytes held is taken from the table as it stands now.
    task automatic push_record(input int unsigned ok, input int unsigned base,
                               input int unsigned cap, input int unsigned src,
                               input int unsigned dst, input int unsigned len,
                               input int unsigned mv, input int unsigned last);
        alloc_record_t rec;
        int unsigned   total;
        int            n;
        total = 0;
        for (n = 0; n < tbl_count; n++)
            total += tbl_size[n];
        rec.ok   = ok[0];
        rec.base = base[ADDR_W-1:0];
        rec.cap  = cap[SIZE_W-1:0];
        rec.held = total[SIZE_W-1:0];
        rec.src  = src[ADDR_W-1:0];
        rec.dst  = dst[ADDR_W-1:0];
        rec.len  = len[SIZE_W-1:0];
        rec.mv   = mv[0];
        rec.last = last[0];
        pending_records.push_back(rec);
    endtask

    // Remove the user's entry, if any, and close up the table.
    task automatic drop_user(input int unsigned user);
        int n;
        int m;
        for (n = 0; n < tbl_count; n++)
        begin
            if (tbl_user[n] == user)
            begin
                for (m = n; m + 1 < tbl_count; m++)
                begin
                    tbl_user[m] = tbl_user[m + 1];
                    tbl_base[m] = tbl_base[m + 1];
                    tbl_size[m] = tbl_size[m + 1];
                end
                tbl_count = tbl_count - 1;
                return;
            end
        end
    endtask

    // Update the shadow table for one accepted request and queue its results.
    task automatic apply_request(input logic [KIND_W-1:0] kind,
                                 input int unsigned user, input int unsigned size);
        int unsigned upool;
        int unsigned pbase;
        int unsigned gap_end;
        int unsigned src;
        int unsigned moved;
        int          n;
        int          m;
        bit          placed;
        upool = (pool_reg < POOL_CAPACITY) ? pool_reg : POOL_CAPACITY;
        case (kind)
            KIND_ALLOC:
            begin
                // Bad size keeps the old block; otherwise release it first.
                if (size == 0 || size > upool)
                begin
                    push_record(0, 0, 0, 0, 0, 0, 0, 1);
                end
                else
                begin
                    drop_user(user);
                    placed = 1'b0;
                    pbase = 0;
                    if (tbl_count < TB_USERS)
                    begin
                        for (n = 0; n <= tbl_count && !placed; n++)
                        begin
                            gap_end = (n < tbl_count) ? tbl_base[n] : upool;
                            // A block past a shrunk pool makes a negative gap: no fit.
                            if (gap_end >= pbase && gap_end - pbase >= size)
                            begin
                                for (m = tbl_count; m > n; m--)
                                begin
                                    tbl_user[m] = tbl_user[m - 1];
                                    tbl_base[m] = tbl_base[m - 1];
                                    tbl_size[m] = tbl_size[m - 1];
                                end
                                tbl_user[n] = user;
                                tbl_base[n] = pbase;
                                tbl_size[n] = size;
                                tbl_count = tbl_count + 1;
                                placed = 1'b1;
                                push_record(1, pbase, size, 0, 0, 0, 0, 1);
                            end
                            else if (n < tbl_count)
                            begin
                                pbase = tbl_base[n] + tbl_size[n];
                            end
                        end
                    end
                    if (!placed)
                        push_record(0, 0, 0, 0, 0, 0, 0, 1);
                end
            end
            KIND_FREE:
            begin
                drop_user(user);
                push_record(1, 0, 0, 0, 0, 0, 0, 1);
            end
            KIND_DEFRAG:
            begin
                if (tbl_count == 0)
                begin
                    push_record(1, 0, 0, 0, 0, 0, 0, 1);
                end
                else
                begin
                    pbase = 0;
                    for (n = 0; n < tbl_count; n++)
                    begin
                        src = tbl_base[n];
                        moved = (src > pbase) ? 1 : 0;
                        if (moved != 0)
                            tbl_base[n] = pbase;
                        pbase = tbl_base[n] + tbl_size[n];
                        push_record(1, 0, 0, src, tbl_base[n], tbl_size[n], moved,
                                    (n + 1 == tbl_count) ? 1 : 0);
                    end
                end
            end
            default:
            begin
                push_record(0, 0, 0, 0, 0, 0, 0, 1);
            end
        endcase
    endtask

    // Offer one request; open a new burst after a random gap when the old one ends.
    // Hold tvalid high across back-to-back requests so it gets a single update.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [USER_W-1:0] user,
                                input logic [SIZE_W-1:0] size,
                                input bit typed, input alloc_record_t typed_rec);
        if (burst_left == 0)
        begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(30, 60);
            else
                burst_left = $urandom_range(1, 12);
        end
        burst_left = burst_left - 1;
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_data  <= {3'b000, size, user};
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        apply_request(kind, user, size);
        // Replace the prediction with the typed-in record for obvious rows.
        if (typed)
        begin
            void'(pending_records.pop_back());
            pending_records.push_back(typed_rec);
        end
    endtask

    // Stop offering requests until every predicted result has drained.
    task automatic settle_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pool(input logic [SIZE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        pool_reg = value;
    endtask

    initial
    begin
        alloc_record_t     rec;
        logic [KIND_W-1:0] kind;
        logic [USER_W-1:0] user;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] pool_pick;
        int unsigned       upool;
        int                pick;
        int                i;
        int                ph;
        int                j;

        errors      = 0;
        burst_left  = 0;
        ready_left  = 0;
        tbl_count   = 0;
        pool_reg    = POOL_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (i = 0; i < DIRECTED_CNT; i++)
        begin
            rec      = '0;
            rec.ok   = directed_rows[i].ok;
            rec.base = directed_rows[i].base;
            rec.cap  = directed_rows[i].cap;
            rec.held = directed_rows[i].held;
            rec.last = 1'b1;
            send_request(directed_rows[i].kind, directed_rows[i].user,
                         directed_rows[i].size, directed_rows[i].typed, rec);
        end

        // Random phases; the pool is rewritten only once the block has drained,
        // which also pauses the sender until every result has come.
        for (ph = 0; ph < PHASE_CNT; ph++)
        begin
            settle_idle();
            pool_pick = phase_pools[ph];
            if (pool_pick == 0)
                pool_pick = SIZE_W'($urandom_range(1, POOL_CAPACITY));
            write_pool(pool_pick);
            upool = (pool_reg < POOL_CAPACITY) ? pool_reg : POOL_CAPACITY;
            for (j = 0; j < PHASE_ITEMS; j++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    kind = KIND_ALLOC;
                else if (pick < 80)
                    kind = KIND_FREE;
                else if (pick < 94)
                    kind = KIND_DEFRAG;
                else
                    kind = KIND_UNKNOWN;
                // Mostly a small user set so the table fills and users re-allocate.
                if ($urandom_range(0, 99) < 85)
                    user = USER_W'($urandom_range(0, 11));
                else
                    user = USER_W'($urandom_range(0, 255));
                pick = $urandom_range(0, 99);
                if (kind != KIND_ALLOC)
                    size = SIZE_W'($urandom_range(0, 8191));
                else if (pick < 75)
                    size = SIZE_W'($urandom_range(1, (upool / 5 > 1) ? upool / 5 : 1));
                else if (pick < 83)
                    size = '0;
                else if (pick < 91)
                    size = SIZE_W'($urandom_range(1, upool));
                else if (pick < 96)
                    size = SIZE_W'($urandom_range(upool + 1, 8191));
                else
                    size = 13'd8191;
                send_request(kind, user, size, 1'b0, '0);
            end
        end

        // Drain, then allow the longest allocate scan and a margin.
        settle_idle();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
design/ffba_pkg.sv
design/ffba_ctrl.sv
design/ffba_dp.sv
design/first_fit_block_allocator_unit.sv
design/ffba_checker.sv
verif/testbench.sv
